// ----- hw/rtl/tcg_pkg.sv -----
`default_nettype none

package tcg_pkg;

    localparam int SAMPLES_DEF  = 7;
    localparam int TABLE_POINTS = 19;
    localparam int ADC_BITS     = 12;
    localparam int DEG_W        = 8;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int LVL_W        = 3;
    localparam int CMD_W        = 2;
    localparam int ZONE_W       = 2;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef logic        [ADC_BITS-1:0] t_adc;
    typedef logic signed [DEG_W-1:0]    t_deg;

    localparam t_adc TAB_ADC [TABLE_POINTS] = '{
        1856, 1799, 1730, 1649, 1556, 1454, 1343, 1227, 1109, 992,
        880, 773, 675, 586, 507, 436, 399, 343, 322
    };
    localparam t_deg TAB_DEG [TABLE_POINTS] = '{
        -20, -15, -10, -5, 0, 5, 10, 15, 20, 25,
        30, 35, 40, 45, 50, 55, 58, 63, 65
    };

    localparam logic [REG_IDX_W-1:0] REG_COLD_CUTOFF = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COOL_LIMIT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WARM_LIMIT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOT_CUTOFF  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHARGE_RATE = 3'd4;

    localparam logic [DEG_W-1:0] RST_COLD_CUTOFF = 8'hFB;
    localparam logic [DEG_W-1:0] RST_COOL_LIMIT  = 8'd0;
    localparam logic [DEG_W-1:0] RST_WARM_LIMIT  = 8'd58;
    localparam logic [DEG_W-1:0] RST_HOT_CUTOFF  = 8'd63;
    localparam logic [CMD_W-1:0] RST_CHARGE_RATE = 2'd1;

    localparam logic [LVL_W-1:0] LVL_OK   = 3'd0;
    localparam logic [LVL_W-1:0] LVL_WARM = 3'd1;
    localparam logic [LVL_W-1:0] LVL_COOL = 3'd2;
    localparam logic [LVL_W-1:0] LVL_HOT  = 3'd3;
    localparam logic [LVL_W-1:0] LVL_COLD = 3'd4;

    localparam logic [ZONE_W-1:0] ZONE_OK   = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_COLD = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_HOT  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd0;
    localparam logic [CMD_W-1:0] RATE_MAX = 2'd2;

    typedef struct packed {
        logic [DEG_W-1:0] cold_cutoff;
        logic [DEG_W-1:0] cool_limit;
        logic [DEG_W-1:0] warm_limit;
        logic [DEG_W-1:0] hot_cutoff;
        logic [CMD_W-1:0] charge_rate;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic take_avg;
        logic search;
        logic mul_lo;
        logic mul_hi;
        logic load_deg;
        logic take_deg;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic last_sample;
        logic div_done;
        logic special;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/tcg_regs.sv -----
`default_nettype none

module tcg_regs import tcg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [DEG_W-1:0]     r_cold_cutoff;
    logic [DEG_W-1:0]     r_cool_limit;
    logic [DEG_W-1:0]     r_warm_limit;
    logic [DEG_W-1:0]     r_hot_cutoff;
    logic [CMD_W-1:0]     r_charge_rate;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold_cutoff <= RST_COLD_CUTOFF;
            r_cool_limit  <= RST_COOL_LIMIT;
            r_warm_limit  <= RST_WARM_LIMIT;
            r_hot_cutoff  <= RST_HOT_CUTOFF;
            r_charge_rate <= RST_CHARGE_RATE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COLD_CUTOFF: r_cold_cutoff <= pwdata[DEG_W-1:0];
                REG_COOL_LIMIT:  r_cool_limit  <= pwdata[DEG_W-1:0];
                REG_WARM_LIMIT:  r_warm_limit  <= pwdata[DEG_W-1:0];
                REG_HOT_CUTOFF:  r_hot_cutoff  <= pwdata[DEG_W-1:0];
                REG_CHARGE_RATE: r_charge_rate <= pwdata[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLD_CUTOFF: prdata = PDATA_W'(r_cold_cutoff);
            REG_COOL_LIMIT:  prdata = PDATA_W'(r_cool_limit);
            REG_WARM_LIMIT:  prdata = PDATA_W'(r_warm_limit);
            REG_HOT_CUTOFF:  prdata = PDATA_W'(r_hot_cutoff);
            REG_CHARGE_RATE: prdata = PDATA_W'(r_charge_rate);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.cold_cutoff = r_cold_cutoff;
    assign o_cfg.cool_limit  = r_cool_limit;
    assign o_cfg.warm_limit  = r_warm_limit;
    assign o_cfg.hot_cutoff  = r_hot_cutoff;
    assign o_cfg.charge_rate = r_charge_rate;

endmodule

`default_nettype wire

// ----- hw/rtl/tcg_ctrl.sv -----
`default_nettype none

module tcg_ctrl import tcg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_sample_valid,
    output logic         o_sample_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MEAN     = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_MUL_LO   = 3'd3;
    localparam logic [2:0] S_MUL_HI   = 3'd4;
    localparam logic [2:0] S_DIV_LOAD = 3'd5;
    localparam logic [2:0] S_DIV_DEG  = 3'd6;
    localparam logic [2:0] S_CLASSIFY = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_sample_valid;
                if (i_sample_valid && i_status.last_sample) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.take_avg = 1'b1;
                n_state        = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = i_status.special ? S_CLASSIFY : S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                o_cmd.load_deg = 1'b1;
                n_state        = S_DIV_DEG;
            end
            S_DIV_DEG: begin
                if (i_status.div_done) begin
                    o_cmd.take_deg = 1'b1;
                    n_state        = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_sample_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/tcg_div.sv -----
`default_nettype none

module tcg_div #(
    parameter int DVD_W = 15,
    parameter int DVS_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic      [DVD_W-1:0] o_quotient,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = (r_cnt == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/tcg_dp.sv -----
`default_nettype none

module tcg_dp import tcg_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire t_cfg                i_cfg,
    input  wire logic [ADC_BITS-1:0] i_sample,
    input  wire logic                i_result_stall,
    output logic                     o_result_valid,
    output logic      [ADC_BITS-1:0] o_average_adc,
    output logic signed [DEG_W-1:0]  o_temperature,
    output logic      [LVL_W-1:0]    o_level,
    output logic      [CMD_W-1:0]    o_charge_command
);

    localparam int CNT_W = $clog2(SAMPLES);
    localparam int SUM_W = ADC_BITS + $clog2(SAMPLES);
    localparam int ACC_W = ADC_BITS + DEG_W + 2;

    // The trimmed mean is a multiply by a rounded-up reciprocal, exact for every SUM_W-bit sum.
    localparam int AVG_DIV = SAMPLES - 2;
    localparam int AVG_SH  = SUM_W + $clog2(AVG_DIV);
    localparam int RCP_W   = AVG_SH + 1;
    localparam int PRD_W   = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(((1 << AVG_SH) + AVG_DIV - 1) / AVG_DIV);

    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum;
    logic [ADC_BITS-1:0]     r_min;
    logic [ADC_BITS-1:0]     r_max;
    logic [ZONE_W-1:0]       r_zone;
    logic [SUM_W-1:0]        r_trim;
    logic [ADC_BITS-1:0]     r_avg;
    logic [IDX_W-1:0]        r_idx;
    logic signed [DEG_W-1:0] r_deg;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic                    r_out_valid;
    logic [ADC_BITS-1:0]     r_out_avg;
    logic signed [DEG_W-1:0] r_out_deg;
    logic [LVL_W-1:0]        r_out_level;
    logic [CMD_W-1:0]        r_out_cmd;

    logic [ADC_BITS-1:0]     min_n;
    logic [ADC_BITS-1:0]     max_n;
    logic [SUM_W-1:0]        sum_n;
    logic [SUM_W-1:0]        trimmed;
    logic                    last_sample;
    logic [PRD_W-1:0]        avg_prod;

    logic                    found;
    logic [IDX_W-1:0]        hit;
    logic                    special;
    logic signed [DEG_W-1:0] special_deg;

    logic [IDX_W-1:0]        idx_hi;
    logic signed [DEG_W-1:0] mul_deg;
    logic [ADC_BITS-1:0]     mul_dist;
    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        abs_acc;

    logic                    div_load;
    logic [SUM_W-1:0]        div_dividend;
    logic [ADC_BITS-1:0]     div_divisor;
    logic [SUM_W-1:0]        div_quotient;
    logic                    div_done;
    logic [DEG_W-1:0]        quo_deg;

    logic [LVL_W-1:0]        level;
    logic [CMD_W-1:0]        on_cmd;
    logic [CMD_W-1:0]        cmd;
    logic [ZONE_W-1:0]       zone_n;

    assign min_n       = (i_sample < r_min) ? i_sample : r_min;
    assign max_n       = (i_sample > r_max) ? i_sample : r_max;
    assign sum_n       = r_sum + SUM_W'(i_sample);
    assign trimmed     = sum_n - SUM_W'(min_n) - SUM_W'(max_n);
    assign last_sample = (r_count == CNT_W'(SAMPLES - 1));
    assign avg_prod    = PRD_W'(r_trim) * PRD_W'(AVG_RCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (i_cmd.accept) begin
            if (last_sample) begin
                r_count <= '0;
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= sum_n;
                r_min   <= min_n;
                r_max   <= max_n;
            end
        end
    end

    // The table falls strictly, so the first entry at or below the mean is its lower neighbor.
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            if (!found && (TAB_ADC[i] <= r_avg)) begin
                found = 1'b1;
                hit   = IDX_W'(i);
            end
        end
    end

    assign special     = !found || (hit == '0) || (TAB_ADC[hit] == r_avg);
    assign special_deg = found ? TAB_DEG[hit] : TAB_DEG[TABLE_POINTS-1];

    assign idx_hi   = r_idx - 1'b1;
    assign mul_deg  = i_cmd.mul_lo ? TAB_DEG[r_idx] : TAB_DEG[idx_hi];
    assign mul_dist = i_cmd.mul_lo ? (TAB_ADC[idx_hi] - r_avg) : (r_avg - TAB_ADC[r_idx]);
    assign prod     = ACC_W'(mul_deg) * ACC_W'($signed({1'b0, mul_dist}));
    assign abs_acc  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    assign div_load     = i_cmd.load_deg;
    assign div_dividend = abs_acc[SUM_W-1:0];
    assign div_divisor  = TAB_ADC[idx_hi] - TAB_ADC[r_idx];
    assign quo_deg      = div_quotient[DEG_W-1:0];

    tcg_div #(
        .DVD_W (SUM_W),
        .DVS_W (ADC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && last_sample) begin
            r_trim <= trimmed;
        end
        if (i_cmd.take_avg) begin
            r_avg <= avg_prod[AVG_SH +: ADC_BITS];
        end
        if (i_cmd.search) begin
            r_idx <= hit;
            r_deg <= special_deg;
        end else if (i_cmd.take_deg) begin
            r_deg <= r_neg ? -$signed(quo_deg) : $signed(quo_deg);
        end
        if (i_cmd.mul_lo) begin
            r_acc <= prod;
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + prod;
        end
        if (i_cmd.load_deg) begin
            r_neg <= r_acc[ACC_W-1];
        end
    end

    always_comb begin
        if (r_deg < $signed(i_cfg.cold_cutoff)) begin
            level = LVL_COLD;
        end else if (r_deg < $signed(i_cfg.cool_limit)) begin
            level = LVL_COOL;
        end else if (r_deg > $signed(i_cfg.hot_cutoff)) begin
            level = LVL_HOT;
        end else if (r_deg > $signed(i_cfg.warm_limit)) begin
            level = LVL_WARM;
        end else begin
            level = LVL_OK;
        end
    end

    assign on_cmd = (i_cfg.charge_rate <= RATE_MAX) ? i_cfg.charge_rate : CMD_OFF;

    always_comb begin
        cmd    = on_cmd;
        zone_n = ZONE_OK;
        case (level)
            LVL_COLD: begin
                cmd    = CMD_OFF;
                zone_n = ZONE_COLD;
            end
            LVL_HOT: begin
                cmd    = CMD_OFF;
                zone_n = ZONE_HOT;
            end
            LVL_COOL: begin
                if (r_zone == ZONE_COLD) begin
                    cmd    = CMD_OFF;
                    zone_n = ZONE_COLD;
                end
            end
            LVL_WARM: begin
                if (r_zone == ZONE_HOT) begin
                    cmd    = CMD_OFF;
                    zone_n = ZONE_HOT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone      <= ZONE_OK;
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_zone      <= zone_n;
            r_out_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_avg   <= r_avg;
            r_out_deg   <= r_deg;
            r_out_level <= level;
            r_out_cmd   <= cmd;
        end
    end

    assign o_status.last_sample = last_sample;
    assign o_status.div_done    = div_done;
    assign o_status.special     = special;
    assign o_status.out_free    = !r_out_valid || !i_result_stall;

    assign o_result_valid   = r_out_valid;
    assign o_average_adc    = r_out_avg;
    assign o_temperature    = r_out_deg;
    assign o_level          = r_out_level;
    assign o_charge_command = r_out_cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/thermistor_charge_guard_core.sv -----
// Channel   Direction  Handshake                          Payload
// sample    in         i_sample_valid / o_sample_stall    i_sample
// result    out        o_result_valid / i_result_stall    o_average_adc, o_temperature,
//                                                         o_level, o_charge_command
// config    in         APB write/read                     pwdata / prdata
//
// A sample that does not close a group is taken without a stall.
// The closing sample stalls the input while the mean, the table search and the interpolation
// run, the last with a one-bit-per-cycle divider; the mean is one multiply.
// Means at a table point or outside the table skip the interpolation.
// The reset is synchronous and active low; it clears the group and the latch.
// A stalled result is held in the output register while further samples of the next group
// are taken; after the closing sample the input stays stalled until that result is transferred.
`default_nettype none

module thermistor_charge_guard_core import tcg_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_sample_valid,
    output logic                     o_sample_stall,
    input  wire logic [ADC_BITS-1:0] i_sample,
    output logic                     o_result_valid,
    input  wire logic                i_result_stall,
    output logic      [ADC_BITS-1:0] o_average_adc,
    output logic signed [DEG_W-1:0]  o_temperature,
    output logic      [LVL_W-1:0]    o_level,
    output logic      [CMD_W-1:0]    o_charge_command,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    tcg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcg_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    tcg_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg            (cfg),
        .i_sample         (i_sample),
        .i_result_stall   (i_result_stall),
        .o_result_valid   (o_result_valid),
        .o_average_adc    (o_average_adc),
        .o_temperature    (o_temperature),
        .o_level          (o_level),
        .o_charge_command (o_charge_command)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tcg_checker.sv -----
`default_nettype none

module tcg_checker import tcg_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_result_valid,
    input wire logic                i_result_stall,
    input wire logic signed [DEG_W-1:0] o_temperature,
    input wire logic [LVL_W-1:0]    o_level,
    input wire logic [CMD_W-1:0]    o_charge_command
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_stall |=>
            o_result_valid && $stable(o_temperature) && $stable(o_level)
            && $stable(o_charge_command))
        else $error("stalled result changed");

    a_cutoff_forces_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_level == LVL_HOT || o_level == LVL_COLD)
            |-> o_charge_command == CMD_OFF)
        else $error("charger on beyond a cutoff");

    a_command_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_charge_command <= RATE_MAX)
        else $error("illegal charge command");

    a_temperature_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_temperature >= -8'sd20 && o_temperature <= 8'sd65)
        else $error("temperature outside the table");

endmodule

bind thermistor_charge_guard_core tcg_checker u_tcg_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tcg_pkg::*;

    localparam int GROUP        = SAMPLES_DEF;
    localparam int ADC_TOP      = (1 << ADC_BITS) - 1;
    localparam int MAX_IDLE     = 17;
    localparam int DRAIN_CYCLES = 48;
    localparam int WALK_GROUPS  = 25;

    localparam logic [REG_IDX_W-1:0] REG_LAST = REG_CHARGE_RATE;

    typedef struct packed {
        t_adc             average;
        t_deg             temperature;
        logic [LVL_W-1:0] level;
        logic [CMD_W-1:0] command;
    } t_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_sample_valid = 1'b0;
    logic                o_sample_stall;
    logic [ADC_BITS-1:0] i_sample = '0;
    logic                o_result_valid;
    logic                i_result_stall = 1'b0;
    logic [ADC_BITS-1:0] o_average_adc;
    logic signed [DEG_W-1:0] o_temperature;
    logic [LVL_W-1:0]    o_level;
    logic [CMD_W-1:0]    o_charge_command;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    thermistor_charge_guard_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_sample_valid),
        .o_sample_stall   (o_sample_stall),
        .i_sample         (i_sample),
        .o_result_valid   (o_result_valid),
        .i_result_stall   (i_result_stall),
        .o_average_adc    (o_average_adc),
        .o_temperature    (o_temperature),
        .o_level          (o_level),
        .o_charge_command (o_charge_command),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #1 i_clk = ~i_clk;

    t_reading expected_readings[$];

    int   group_count;
    int   group_sum;
    t_adc group_min;
    t_adc group_max;
    logic [ZONE_W-1:0] latch_zone;
    t_deg cold_cut;
    t_deg cool_lim;
    t_deg warm_lim;
    t_deg hot_cut;
    logic [CMD_W-1:0] rate_sel;

    int mismatches = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int settings_applied = 0;
    int level_seen [0:4] = '{0, 0, 0, 0, 0};
    int walk_adc = 1100;
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    function automatic int adc_to_celsius(input int adc);
        int i;
        int lo_adc;
        int hi_adc;
        int lo_deg;
        int hi_deg;
        if (adc >= int'(TAB_ADC[0])) begin
            return int'(TAB_DEG[0]);
        end
        if (adc <= int'(TAB_ADC[TABLE_POINTS-1])) begin
            return int'(TAB_DEG[TABLE_POINTS-1]);
        end
        for (i = 1; i < TABLE_POINTS; i++) begin
            lo_adc = TAB_ADC[i];
            if (adc >= lo_adc) begin
                hi_adc = TAB_ADC[i-1];
                lo_deg = TAB_DEG[i];
                hi_deg = TAB_DEG[i-1];
                if (adc == lo_adc) begin
                    return lo_deg;
                end
                return (lo_deg * (hi_adc - adc) + hi_deg * (adc - lo_adc)) / (hi_adc - lo_adc);
            end
        end
        return int'(TAB_DEG[TABLE_POINTS-1]);
    endfunction

    function automatic void clear_group();
        group_count = 0;
        group_sum   = 0;
        group_min   = t_adc'(ADC_TOP);
        group_max   = '0;
    endfunction

    function automatic void absorb_sample(input t_adc s);
        int avg;
        int deg;
        logic [LVL_W-1:0] lvl;
        logic [CMD_W-1:0] cmd;
        logic [CMD_W-1:0] on_cmd;
        t_reading r;
        samples_sent++;
        group_sum += s;
        if (s < group_min) begin
            group_min = s;
        end
        if (s > group_max) begin
            group_max = s;
        end
        group_count++;
        if (group_count < GROUP) begin
            return;
        end
        avg = (group_sum - group_min - group_max) / (GROUP - 2);
        clear_group();
        deg = adc_to_celsius(avg);
        if (deg < cold_cut) begin
            lvl = LVL_COLD;
        end else if (deg < cool_lim) begin
            lvl = LVL_COOL;
        end else if (deg > hot_cut) begin
            lvl = LVL_HOT;
        end else if (deg > warm_lim) begin
            lvl = LVL_WARM;
        end else begin
            lvl = LVL_OK;
        end
        on_cmd = (rate_sel <= RATE_MAX) ? rate_sel : CMD_OFF;
        case (lvl)
            LVL_COLD: begin
                cmd = CMD_OFF;
                latch_zone = ZONE_COLD;
            end
            LVL_HOT: begin
                cmd = CMD_OFF;
                latch_zone = ZONE_HOT;
            end
            LVL_COOL: begin
                if (latch_zone == ZONE_COLD) begin
                    cmd = CMD_OFF;
                end else begin
                    cmd = on_cmd;
                    latch_zone = ZONE_OK;
                end
            end
            LVL_WARM: begin
                if (latch_zone == ZONE_HOT) begin
                    cmd = CMD_OFF;
                end else begin
                    cmd = on_cmd;
                    latch_zone = ZONE_OK;
                end
            end
            default: begin
                cmd = on_cmd;
                latch_zone = ZONE_OK;
            end
        endcase
        level_seen[lvl]++;
        r.average     = avg[ADC_BITS-1:0];
        r.temperature = deg[DEG_W-1:0];
        r.level       = lvl;
        r.command     = cmd;
        expected_readings.push_back(r);
    endfunction

    always @(posedge i_clk) begin : check_result
        t_reading want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1 && i_result_stall === 1'b0) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected result transfer: average_adc %0d", o_average_adc);
                mismatches++;
            end else begin
                want = expected_readings.pop_front();
                results_checked++;
                if (o_average_adc !== want.average) begin
                    $error("average_adc expected %0d actual %0d", want.average, o_average_adc);
                    mismatches++;
                end
                if (o_temperature !== want.temperature) begin
                    $error("temperature expected %0d actual %0d",
                           want.temperature, o_temperature);
                    mismatches++;
                end
                if (o_level !== want.level) begin
                    $error("level expected %0d actual %0d", want.level, o_level);
                    mismatches++;
                end
                if (o_charge_command !== want.command) begin
                    $error("charge_command expected %0d actual %0d",
                           want.command, o_charge_command);
                    mismatches++;
                end
            end
        end
    end

    initial begin : result_stall_driver
        int hold;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(7, 0) == 0) begin
                recv_quiet = !recv_quiet;
            end
            hold = recv_quiet ? 0 : $urandom_range(MAX_IDLE, 0);
            if (hold > 0) begin
                i_result_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_result_stall <= 1'b0;
            do @(posedge i_clk); while (o_result_valid !== 1'b1);
        end
    end

    // The valid stays high after a transfer so that back-to-back samples need no
    // second assignment in one step; any caller that waits must lower it first.
    task automatic send_sample(input t_adc s);
        int gap;
        if ($urandom_range(39, 0) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (o_sample_stall !== 1'b0);
        absorb_sample(s);
    endtask

    task automatic wait_for_idle();
        i_sample_valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        logic [PDATA_W-1:0] data;
        data = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COLD_CUTOFF: cold_cut = data[DEG_W-1:0];
            REG_COOL_LIMIT:  cool_lim = data[DEG_W-1:0];
            REG_WARM_LIMIT:  warm_lim = data[DEG_W-1:0];
            REG_HOT_CUTOFF:  hot_cut  = data[DEG_W-1:0];
            REG_CHARGE_RATE: rate_sel = data[CMD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int cold, input int cool, input int warm,
                                  input int hot, input int rate);
        logic [REG_IDX_W-1:0] spare;
        wait_for_idle();
        write_reg(REG_COLD_CUTOFF, cold);
        write_reg(REG_COOL_LIMIT, cool);
        write_reg(REG_WARM_LIMIT, warm);
        write_reg(REG_HOT_CUTOFF, hot);
        write_reg(REG_CHARGE_RATE, rate);
        spare = REG_IDX_W'($urandom_range(2 ** REG_IDX_W - 1, REG_LAST + 1));
        write_reg(spare, $urandom);
        settings_applied++;
    endtask

    task automatic send_group(input int target, input int spread);
        t_adc vals [GROUP];
        int lo_pos;
        int hi_pos;
        int mid_min;
        int mid_max;
        int v;
        int i;
        lo_pos  = $urandom_range(GROUP - 1, 0);
        hi_pos  = (lo_pos + $urandom_range(GROUP - 1, 1)) % GROUP;
        mid_min = ADC_TOP;
        mid_max = 0;
        for (i = 0; i < GROUP; i++) begin
            if (i != lo_pos && i != hi_pos) begin
                v = target + $urandom_range(2 * spread, 0) - spread;
                v = (v < 0) ? 0 : (v > ADC_TOP) ? ADC_TOP : v;
                vals[i] = t_adc'(v);
                mid_min = (v < mid_min) ? v : mid_min;
                mid_max = (v > mid_max) ? v : mid_max;
            end
        end
        vals[lo_pos] = t_adc'($urandom_range(mid_min, 0));
        vals[hi_pos] = t_adc'($urandom_range(ADC_TOP, mid_max));
        for (i = 0; i < GROUP; i++) begin
            send_sample(vals[i]);
        end
    endtask

    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_sample(t_adc'($urandom_range(ADC_TOP, 0)));
        end
    endtask

    task automatic run_walk(input int groups);
        int g;
        int pick;
        for (g = 0; g < groups; g++) begin
            pick = $urandom_range(19, 0);
            if (pick < 2) begin
                send_group(TAB_ADC[$urandom_range(TABLE_POINTS - 1, 0)], 0);
            end else if (pick < 3) begin
                send_group($urandom_range(TAB_ADC[TABLE_POINTS-1] - 1, 0), 20);
            end else if (pick < 4) begin
                send_group($urandom_range(ADC_TOP, TAB_ADC[0] + 1), 20);
            end else if (pick < 6) begin
                send_noise(GROUP);
            end else begin
                walk_adc += $urandom_range(240, 0) - 120;
                walk_adc = (walk_adc < 280) ? 280 : (walk_adc > 1900) ? 1900 : walk_adc;
                send_group(walk_adc, $urandom_range(12, 0));
            end
        end
    endtask

    task automatic test_table_ends();
        int i;
        send_sample(t_adc'(ADC_TOP));
        for (i = 1; i < GROUP; i++) begin
            send_sample('0);
        end
        send_sample('0);
        for (i = 1; i < GROUP; i++) begin
            send_sample(t_adc'(ADC_TOP));
        end
        send_sample('0);
        for (i = 2; i < GROUP; i++) begin
            send_sample(TAB_ADC[8]);
        end
        send_sample(t_adc'(ADC_TOP));
    endtask

    task automatic test_threshold_phases();
        int p;
        int a;
        int b;
        int c;
        int d;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: apply_settings(-5, 0, 58, 63, 2);
                1: apply_settings(-40, -40, 100, 100, 1);
                2: apply_settings(100, 100, -40, -40, 0);
                3: apply_settings(10, 20, 40, 50, 3);
                4: begin
                    a = $urandom_range(29, 0) - 25;
                    b = a + $urandom_range(24, 0);
                    c = b + $urandom_range(29, 0);
                    d = c + $urandom_range(19, 0);
                    apply_settings(a, b, c, d, $urandom_range(2, 0));
                end
                default: begin
                    apply_settings($urandom_range(140, 0) - 40, $urandom_range(140, 0) - 40,
                                   $urandom_range(140, 0) - 40, $urandom_range(140, 0) - 40,
                                   $urandom_range(3, 0));
                end
            endcase
            run_walk(WALK_GROUPS);
        end
    endtask

    task automatic test_broken_groups();
        int k;
        apply_settings(-5, 0, 58, 63, 1);
        for (k = 0; k < 8; k++) begin
            send_noise($urandom_range(6, 1));
            run_walk(2);
            while (group_count != 0) begin
                send_sample(t_adc'($urandom_range(ADC_TOP, 0)));
            end
        end
    endtask

    initial begin
        cold_cut   = RST_COLD_CUTOFF;
        cool_lim   = RST_COOL_LIMIT;
        warm_lim   = RST_WARM_LIMIT;
        hot_cut    = RST_HOT_CUTOFF;
        rate_sel   = RST_CHARGE_RATE;
        latch_zone = ZONE_OK;
        clear_group();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_ends();
        test_threshold_phases();
        test_broken_groups();
        wait_for_idle();
        $display("tb: %0d samples over %0d register settings, %0d results checked",
                 samples_sent, settings_applied, results_checked);
        $display("tb: levels ok %0d, warm %0d, cool %0d, too hot %0d, too cold %0d",
                 level_seen[LVL_OK], level_seen[LVL_WARM], level_seen[LVL_COOL],
                 level_seen[LVL_HOT], level_seen[LVL_COLD]);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: timeout with %0d results outstanding", expected_readings.size());
        $display("tb: failure");
        $finish;
    end

endmodule
